// ----- hdl/asa_pkg.sv -----
// ----------------------------------------------------------------------------
// asa_pkg
// Shared types, constants and codes of the aligned stack allocator.
// ----------------------------------------------------------------------------
package asa_pkg;

    // Sizing of the allocation record stack and of the address arithmetic
    localparam int RECORD_DEPTH = 64;
    localparam int ADDR_BITS    = 48;

    // Field widths of the transfer payloads and configuration registers
    localparam int FIELD_ADDR_W = 48;
    localparam int USED_W       = 33;
    localparam int REQ_W        = 31;
    localparam int ALIGN_W      = 4;
    localparam int STATUS_W     = 2;

    // Padding never exceeds 2^15 - 1, the largest alignment code
    localparam int PAD_W  = 16;
    // used + pad + request can exceed 2^33, so give the sum 35 bits
    localparam int NEED_W = 35;

    localparam int REC_IDX_W = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
    localparam int REC_CNT_W = $clog2(RECORD_DEPTH + 1);

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALIGN = 2'd2;

    localparam logic [USED_W-1:0]  CAP_RESET   = 33'd1024;
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd3;

    // Request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE   = 2'd3;

    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef struct packed {
        logic                    op;
        logic [REQ_W-1:0]        request_bytes;
        logic [FIELD_ADDR_W-1:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [FIELD_ADDR_W-1:0] granted_address;
        logic [USED_W-1:0]       bytes_in_use;
    } t_out_item;

    // One entry of the record stack
    typedef struct packed {
        logic [USED_W-1:0]       prior_used;
        logic [FIELD_ADDR_W-1:0] address;
    } t_record;

    typedef struct packed {
        logic                    op;
        logic [REQ_W-1:0]        request_bytes;
        logic [FIELD_ADDR_W-1:0] free_address;
        t_addr                   top;
        logic [USED_W-1:0]       used;
        logic [REC_CNT_W-1:0]    depth;
        logic [USED_W-1:0]       capacity;
        logic [ALIGN_W-1:0]      align_log2;
        t_record                 rec;
    } t_eval_in;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [FIELD_ADDR_W-1:0] granted_address;
        logic [USED_W-1:0]       used_next;
        logic                    push;
        logic                    pop;
    } t_eval_out;

endpackage

// ----- hdl/asa_ram.sv -----
// ----------------------------------------------------------------------------
// asa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module asa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/asa_eval.sv -----
// ----------------------------------------------------------------------------
// asa_eval
// Decision logic for one request: padding, space check, stack checks.
// ----------------------------------------------------------------------------
module asa_eval (
    input  asa_pkg::t_eval_in  i_eval,
    output asa_pkg::t_eval_out o_eval
);
    import asa_pkg::*;

    logic [PAD_W-1:0]  pad_mask;
    logic [PAD_W-1:0]  pad;
    logic [NEED_W-1:0] need;
    t_addr             granted_a;
    logic              fits;
    logic              full;

    // Distance from the top up to the next aligned boundary
    assign pad_mask  = PAD_W'(((PAD_W+1)'(1) << i_eval.align_log2) - (PAD_W+1)'(1));
    assign pad       = (PAD_W'(0) - i_eval.top[PAD_W-1:0]) & pad_mask;
    assign need      = NEED_W'(i_eval.used) + NEED_W'(pad) + NEED_W'(i_eval.request_bytes);
    assign granted_a = i_eval.top + ADDR_BITS'(pad);
    assign fits      = (need <= NEED_W'(i_eval.capacity));
    assign full      = (i_eval.depth >= REC_CNT_W'(RECORD_DEPTH));

    always_comb begin
        o_eval.status          = ST_OK;
        o_eval.granted_address = '0;
        o_eval.used_next       = i_eval.used;
        o_eval.push            = 1'b0;
        o_eval.pop             = 1'b0;
        if (i_eval.op == OP_ALLOC) begin
            if (!fits) begin
                o_eval.status = ST_NO_SPACE;
            end else if (full) begin
                o_eval.status = ST_STACK_FULL;
            end else begin
                o_eval.granted_address = FIELD_ADDR_W'(granted_a);
                o_eval.used_next       = need[USED_W-1:0];
                o_eval.push            = 1'b1;
            end
        end else begin
            // Honor a free only for the newest record
            if (i_eval.depth == '0 || i_eval.rec.address != i_eval.free_address) begin
                o_eval.status = ST_BAD_FREE;
            end else begin
                o_eval.used_next = i_eval.rec.prior_used;
                o_eval.pop       = 1'b1;
            end
        end
    end

endmodule

// ----- hdl/aligned_stack_allocator.sv -----
// ----------------------------------------------------------------------------
// aligned_stack_allocator
// LIFO region allocator with power-of-two alignment and a record stack.
// ----------------------------------------------------------------------------
// Each request passes through the transfer cycle, in which the current top
// address (base + bytes in use) is formed and the newest record is read from
// the record memory, and an evaluate cycle, in which the record read data is
// back and the request is decided, the record memory is written on a grant,
// and the result is loaded into the output register. The record memory has a
// registered read port, hence the evaluate cycle. No new request is taken
// until the current one is decided, and the evaluate cycle holds as long as
// the output register is still full and not being taken. A result waiting in
// the output register does not block the next request from being accepted.
// Records live in a 64-entry memory with no reset; only entries below the
// current depth are ever used. Configuration writes are meant to happen only
// while the block is idle; register 3 of the index space is ignored.
// ----------------------------------------------------------------------------
module aligned_stack_allocator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  asa_pkg::t_in_item                     i_in_data,
    // Result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output asa_pkg::t_out_item                    o_out_data,
    // Configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [asa_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [asa_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);
    import asa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    // Configuration registers
    logic [FIELD_ADDR_W-1:0] r_base;
    logic [USED_W-1:0]       r_cap;
    logic [ALIGN_W-1:0]      r_align;

    // Allocator state
    logic [USED_W-1:0]       r_used;
    logic [REC_CNT_W-1:0]    r_depth;
    logic                    r_state;

    // Captured request and its top address
    t_in_item                r_item;
    t_addr                   r_top;

    // Output register
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    in_xfer;
    logic                    commit;
    t_eval_in                eval_in;
    t_eval_out               eval_out;
    t_record                 rd_rec;
    t_record                 wr_rec;
    logic                    wr_en;
    logic [REC_IDX_W-1:0]    wr_addr;
    logic [REC_IDX_W-1:0]    rd_addr;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    // Decide the request once the output register can take the result
    assign commit      = (r_state == S_EVAL) && (!r_out_valid || i_out_ready);

    // The newest record sits one below the depth; read it every cycle so the
    // data is ready in the evaluate cycle. Depth zero wraps to a don't-care.
    assign rd_addr = REC_IDX_W'(r_depth - REC_CNT_W'(1));
    assign wr_addr = REC_IDX_W'(r_depth);
    assign wr_en   = commit && eval_out.push;
    assign wr_rec  = '{prior_used: r_used, address: eval_out.granted_address};

    asa_ram #(
        .WIDTH ($bits(t_record)),
        .DEPTH (RECORD_DEPTH)
    ) u_rec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_rec),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_rec)
    );

    always_comb begin
        eval_in.op            = r_item.op;
        eval_in.request_bytes = r_item.request_bytes;
        eval_in.free_address  = r_item.free_address;
        eval_in.top           = r_top;
        eval_in.used          = r_used;
        eval_in.depth         = r_depth;
        eval_in.capacity      = r_cap;
        eval_in.align_log2    = r_align;
        eval_in.rec           = rd_rec;
    end

    asa_eval u_eval (
        .i_eval (eval_in),
        .o_eval (eval_out)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_cap   <= CAP_RESET;
            r_align <= ALIGN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_wdata[FIELD_ADDR_W-1:0];
                CFG_CAP:   r_cap   <= i_cfg_wdata[USED_W-1:0];
                CFG_ALIGN: r_align <= i_cfg_wdata[ALIGN_W-1:0];
                default:   ;
            endcase
        end
    end

    // Control state: sequencer, used count, record depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_depth <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                        r_used  <= eval_out.used_next;
                        if (eval_out.push) begin
                            r_depth <= r_depth + REC_CNT_W'(1);
                        end else if (eval_out.pop) begin
                            r_depth <= r_depth - REC_CNT_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Capture the request and form the wrapped top address
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_data;
            r_top  <= ADDR_BITS'(r_base) + ADDR_BITS'(r_used);
        end
    end

    // Output register: load on commit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out.status          <= eval_out.status;
            r_out.granted_address <= eval_out.granted_address;
            r_out.bytes_in_use    <= eval_out.used_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The record depth never runs past the stack size
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= REC_CNT_W'(RECORD_DEPTH))
        else $error("record depth beyond stack size");

    // A record is written only into a free slot
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_depth < REC_CNT_W'(RECORD_DEPTH)))
        else $error("record pushed onto a full stack");

    // A refused request leaves the used count and depth alone
    a_refuse_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && eval_out.status != ST_OK)
            |=> (r_used == $past(r_used) && r_depth == $past(r_depth)))
        else $error("refused request changed allocator state");

    // Every committed request shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (o_out_valid && o_out_data.bytes_in_use == r_used))
        else $error("committed request produced no matching result");
`endif

endmodule
